@@ sv/lpt_pkg.sv @@
// Shared constants and types for the patience-sorting LIS length block.
`timescale 1ns / 1ps
`default_nettype none

package lpt_pkg;

  localparam int LPT_MAX_LEN        = 1024;
  localparam int LPT_VALUE_BITS     = 32;
  localparam int LPT_OUT_LEN_BITS   = 11;

  // Control that travels with an item from one tail cell to the next.
  typedef struct packed {
    logic valid;   // stage holds an item
    logic placed;  // item already landed in an earlier cell
    logic first;   // item opens a new sequence
    logic last;    // item closes the sequence (echoed only)
  } lpt_ctrl_t;

endpackage : lpt_pkg

`default_nettype wire

@@ sv/lpt_if.sv @@
// Valid/ready channel interfaces for the input items and the result items.
`timescale 1ns / 1ps
`default_nettype none

interface lpt_in_if #(
  parameter int VALUE_BITS = 32
) ();
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] value;
  logic                         first;
  logic                         last;

  modport source (output valid, value, first, last, input ready);
  modport sink   (input valid, value, first, last, output ready);
endinterface : lpt_in_if

interface lpt_out_if #(
  parameter int LEN_BITS = 11
) ();
  logic                valid;
  logic                ready;
  logic [LEN_BITS-1:0] lis_length;
  logic                overflow;
  logic                end_of_sequence;

  modport source (output valid, lis_length, overflow, end_of_sequence, input ready);
  modport sink   (input valid, lis_length, overflow, end_of_sequence, output ready);
endinterface : lpt_out_if

`default_nettype wire

@@ sv/lpt_cell.sv @@
// One tail cell: holds one table entry and passes the item on through its stage register when the row advances.
`timescale 1ns / 1ps
`default_nettype none

module lpt_cell
  import lpt_pkg::*;
#(
  parameter int VALUE_BITS = LPT_VALUE_BITS,
  parameter int LEN_BITS   = 11
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  advance,
  input  wire lpt_ctrl_t             ctrl_in,
  input  wire logic [VALUE_BITS-1:0] key_in,
  input  wire logic [LEN_BITS-1:0]   len_in,
  output lpt_ctrl_t                  ctrl_out,
  output logic      [VALUE_BITS-1:0] key_out,
  output logic      [LEN_BITS-1:0]   len_out
);

  logic [VALUE_BITS-1:0] tail_r;
  logic                  occ_r;
  lpt_ctrl_t             ctrl_r;
  logic [VALUE_BITS-1:0] key_r;
  logic [LEN_BITS-1:0]   len_r;

  logic      occ_eff;
  logic      hit;
  logic      occ_nxt;
  lpt_ctrl_t ctrl_nxt;

  // A first flag empties the entry before the item looks at it.
  assign occ_eff = occ_r & ~ctrl_in.first;
  // Land here when the entry is empty (append) or its tail is not less than the key.
  assign hit     = ctrl_in.valid & ~ctrl_in.placed & (~occ_eff | (tail_r >= key_in));
  assign occ_nxt = occ_eff | hit;

  always_comb begin
    ctrl_nxt        = ctrl_in;
    ctrl_nxt.placed = ctrl_in.placed | hit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r        <= 1'b0;
      ctrl_r.valid <= 1'b0;
    end else if (advance) begin
      if (ctrl_in.valid) begin
        occ_r <= occ_nxt;
      end
      ctrl_r.valid <= ctrl_in.valid;
    end
    if (advance) begin
      if (hit) begin
        tail_r <= key_in;
      end
      ctrl_r.placed <= ctrl_nxt.placed;
      ctrl_r.first  <= ctrl_nxt.first;
      ctrl_r.last   <= ctrl_nxt.last;
      key_r         <= key_in;
      len_r         <= len_in + LEN_BITS'(occ_nxt);
    end
  end

  assign ctrl_out = ctrl_r;
  assign key_out  = key_r;
  assign len_out  = len_r;

endmodule : lpt_cell

`default_nettype wire

@@ sv/lis_length_patience_tails.sv @@
// Top level: running longest strictly increasing subsequence length.
//
// Usage:
//   in_chan  (valid/ready): value, first, last. An item moves on a cycle with
//            valid and ready both high. first empties the tail table before
//            the value is used; last is echoed on the matching result.
//   out_chan (valid/ready): lis_length, overflow, end_of_sequence, one result
//            per input item, in input order.
// The table lives in a row of MAX_LEN tail cells. Each item walks the row one
// cell per cycle while the row advances, and lands in the first cell that is
// empty or whose tail is not less than its key. The row takes a new item before the last one leaves it.
// Pipeline: the item is registered in cell 0 at the accepting edge, then in each
//   further cell in turn and then in the output register. Throughput: one item per
//   cycle while out_chan does not stall.
// Reset: all cells empty, length zero, overflow clear; the first item after
//   reset starts a sequence even without its first flag.
// Stall: while a result waits on out_chan, the whole row holds and in_chan
//   ready drops; nothing is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none

module lis_length_patience_tails
  import lpt_pkg::*;
#(
  parameter int MAX_LEN    = LPT_MAX_LEN,
  parameter int VALUE_BITS = LPT_VALUE_BITS
) (
  input  wire logic clk,
  input  wire logic rst_n,
  lpt_in_if.sink    in_chan,
  lpt_out_if.source out_chan
);

  localparam int LEN_BITS = $clog2(MAX_LEN + 1);

  // Item stage wires between cells; index 0 is the row entry.
  lpt_ctrl_t             ctrl_w [0:MAX_LEN];
  logic [VALUE_BITS-1:0] key_w  [0:MAX_LEN];
  logic [LEN_BITS-1:0]   len_w  [0:MAX_LEN];

  logic advance;

  // Output register and sticky overflow.
  logic                        out_valid_r;
  logic [LPT_OUT_LEN_BITS-1:0] out_len_r;
  logic                        out_ovf_r;
  logic                        out_eos_r;
  logic                        ovf_r;
  logic                        ovf_nxt;

  // Advance the whole row whenever the output register is free or emptying.
  assign advance       = ~out_valid_r | out_chan.ready;
  assign in_chan.ready = advance;

  // Map the signed value to an unsigned order key: flip the sign bit.
  assign ctrl_w[0] = '{valid: in_chan.valid, placed: 1'b0, first: in_chan.first,
                       last: in_chan.last};
  assign key_w[0]  = in_chan.value ^ {1'b1, {(VALUE_BITS-1){1'b0}}};
  assign len_w[0]  = '0;

  for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
    lpt_cell #(
      .VALUE_BITS(VALUE_BITS),
      .LEN_BITS  (LEN_BITS)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .advance (advance),
      .ctrl_in (ctrl_w[i]),
      .key_in  (key_w[i]),
      .len_in  (len_w[i]),
      .ctrl_out(ctrl_w[i+1]),
      .key_out (key_w[i+1]),
      .len_out (len_w[i+1])
    );
  end

  // An item that leaves the row unplaced found a full table: raise overflow.
  // The sticky flag follows item order, so it is kept here at the row exit.
  assign ovf_nxt = (ovf_r & ~ctrl_w[MAX_LEN].first) | ~ctrl_w[MAX_LEN].placed;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      ovf_r       <= 1'b0;
    end else if (advance) begin
      out_valid_r <= ctrl_w[MAX_LEN].valid;
      if (ctrl_w[MAX_LEN].valid) begin
        ovf_r <= ovf_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && ctrl_w[MAX_LEN].valid) begin
      out_len_r <= LPT_OUT_LEN_BITS'(len_w[MAX_LEN]);
      out_ovf_r <= ovf_nxt;
      out_eos_r <= ctrl_w[MAX_LEN].last;
    end
  end

  assign out_chan.valid           = out_valid_r;
  assign out_chan.lis_length      = out_len_r;
  assign out_chan.overflow        = out_ovf_r;
  assign out_chan.end_of_sequence = out_eos_r;

endmodule : lis_length_patience_tails

`default_nettype wire

@@ sv/lpt_checker.sv @@
// Port-level checks for the LIS length block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module lpt_checker
  import lpt_pkg::*;
#(
  parameter int MAX_LEN = LPT_MAX_LEN
) (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_ready,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [LPT_OUT_LEN_BITS-1:0] out_lis_length,
  input wire logic                        out_overflow,
  input wire logic                        out_end_of_sequence
);

  localparam logic [LPT_OUT_LEN_BITS-1:0] FULL_LEN = LPT_OUT_LEN_BITS'(MAX_LEN);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_lis_length) && $stable(out_overflow)
                               && $stable(out_end_of_sequence))
    else $error("result changed while stalled");

  a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow output room");

  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_lis_length != '0 || MAX_LEN >= (1 << LPT_OUT_LEN_BITS))
    else $error("zero length reported");

  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_overflow |-> out_lis_length == FULL_LEN)
    else $error("overflow reported with table not full");

endmodule : lpt_checker

bind lis_length_patience_tails lpt_checker #(
  .MAX_LEN(MAX_LEN)
) u_lpt_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_ready           (in_chan.ready),
  .out_valid          (out_chan.valid),
  .out_ready          (out_chan.ready),
  .out_lis_length     (out_chan.lis_length),
  .out_overflow       (out_chan.overflow),
  .out_end_of_sequence(out_chan.end_of_sequence)
);

`default_nettype wire
